/* rtl/dq_pkg.sv */
package dq_pkg;

    // command codes carried by a request beat
    typedef enum logic [1:0] {
        CMD_PUSH_HEAD = 2'd0,
        CMD_PUSH_TAIL = 2'd1,
        CMD_POP_HEAD  = 2'd2,
        CMD_POP_TAIL  = 2'd3
    } cmd_t;

    // status codes carried by a response beat
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

/* rtl/dq_if.sv */
// request channel: one command per beat
interface dq_req_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    dq_pkg::cmd_t          command;
    logic [DATA_WIDTH-1:0] data_in;

    modport source (output valid, output command, output data_in, input ready);
    modport sink   (input valid, input command, input data_in, output ready);
endinterface

// response channel: one result per beat
interface dq_rsp_if #(
    parameter int DATA_WIDTH  = 32,
    parameter int COUNT_WIDTH = 5
);
    logic                   valid;
    logic                   ready;
    logic [DATA_WIDTH-1:0]  data_out;
    dq_pkg::status_t        status;
    logic [COUNT_WIDTH-1:0] count;

    modport source (output valid, output data_out, output status, output count, input ready);
    modport sink   (input valid, input data_out, input status, input count, output ready);
endinterface

/* rtl/dq_ram.sv */
module dq_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_WIDTH = 4
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_WIDTH-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_WIDTH-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/double_ended_queue_unit.sv */
// Bounded double-ended queue of DEPTH words, kept in a ring memory.
// req (sink): one beat per command: push at head, push at tail, pop from
//   head or pop from tail; data_in is used by pushes only.
// rsp (source): exactly one beat per command, in command order, with the
//   word removed by a successful pop (zero otherwise), a status (ok, pop on
//   empty, push on full) and the number of entries held after the command.
// The response is valid in the cycle after its request beat, when the
//   memory's registered read port has the word ready for a pop.
// Throughput: one command per cycle while rsp is not stalled; each command
//   does a single read or a single write of the memory, so a pop may directly
//   follow a push to the same entry without forwarding.
// A push on a full queue is dropped; a pop on an empty queue changes nothing.
// Reset clears the front pointer and the count; the memory is not cleared,
//   only occupied entries are ever read.
// When rsp is stalled, the pending response holds and req.ready drops; it
//   rises again in the cycle the response is taken.
// The interfaces must be instantiated with the same DATA_WIDTH and with
//   COUNT_WIDTH = $clog2(DEPTH + 1).
module double_ended_queue_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    dq_req_if.sink       req,
    dq_rsp_if.source     rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 2;

    logic [AW-1:0]         front_reg, front_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  res_valid_reg, res_valid_next;
    dq_pkg::status_t       res_status_reg, res_status_next;
    logic [CW-1:0]         res_count_reg;
    logic                  res_pop_reg, res_pop_next;

    logic                  accept;
    logic                  full, empty;
    logic [AW-1:0]         front_dec, front_inc;
    logic [SW-1:0]         tail_sum, last_sum;
    logic [AW-1:0]         tail_pos, last_pos;
    logic                  wr_en, rd_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    // handshake
    assign req.ready = !res_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // ring positions around the front pointer
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);

    assign tail_sum = SW'(front_reg) + SW'(count_reg);
    assign last_sum = tail_sum - SW'(1);
    assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign last_pos = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

    // command decode: pointer update and at most one memory access
    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_pos;
        rd_en           = 1'b0;
        rd_addr         = front_reg;
        res_status_next = dq_pkg::ST_OK;
        res_pop_next    = 1'b0;
        case (req.command)
            dq_pkg::CMD_PUSH_HEAD:
            begin
                if (full)
                begin
                    res_status_next = dq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = accept;
                    wr_addr    = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            dq_pkg::CMD_PUSH_TAIL:
            begin
                if (full)
                begin
                    res_status_next = dq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = accept;
                    wr_addr    = tail_pos;
                    count_next = count_reg + CW'(1);
                end
            end
            dq_pkg::CMD_POP_HEAD:
            begin
                if (empty)
                begin
                    res_status_next = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en        = accept;
                    rd_addr      = front_reg;
                    res_pop_next = 1'b1;
                    front_next   = front_inc;
                    count_next   = count_reg - CW'(1);
                end
            end
            dq_pkg::CMD_POP_TAIL:
            begin
                if (empty)
                begin
                    res_status_next = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en        = accept;
                    rd_addr      = last_pos;
                    res_pop_next = 1'b1;
                    count_next   = count_reg - CW'(1);
                end
            end
            default:
            begin
                res_status_next = dq_pkg::ST_OK;
            end
        endcase
    end

    // response valid: set by a request beat, cleared when taken
    always_comb
    begin
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_status_reg <= res_status_next;
            res_count_reg  <= count_next;
            res_pop_reg    <= res_pop_next;
        end
    end

    // entry store
    dq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_WIDTH (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.data_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // response outputs
    assign rsp.valid    = res_valid_reg;
    assign rsp.status   = res_status_reg;
    assign rsp.count    = res_count_reg;
    assign rsp.data_out = res_pop_reg ? rd_data : '0;

endmodule
